// ===== hw/rtl/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg
// shared types and constants of the 3x3 rgb convolution filter
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int PIX_W  = 24;
    localparam int COEF_W = 16;
    localparam int ROW_W  = 48;
    localparam int ACC_W  = 29;
    localparam int SUM_W  = 20;
    localparam int QW     = 29;

    localparam logic [2:0] REG_TOP    = 3'd0;
    localparam logic [2:0] REG_MID    = 3'd1;
    localparam logic [2:0] REG_BOT    = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic load;       // latch pixel, read line stores
        logic shift;      // shift window, write line stores
        logic mac_clr;    // start of accumulation
        logic mac_step;   // one kernel tap
        logic div_start;  // start dividers
        logic out_load;   // capture result
    } rkc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic tap_last;
    } rkc_stat_t;

endpackage

// ===== hw/rtl/rkc_ram.sv =====
// ----------------------------------------------------------------------------
// rkc_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module rkc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/rkc_datapath.sv =====
// ----------------------------------------------------------------------------
// rkc_datapath
// line stores, window, serial mac and serial dividers of the filter
// ----------------------------------------------------------------------------
module rkc_datapath import rkc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rkc_cmd_t                      cmd,
    output rkc_stat_t                     stat,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col_idx,
    input  logic [PIX_W-1:0]              pix_in,
    input  logic [ROW_W-1:0]              coef_top,
    input  logic [ROW_W-1:0]              coef_mid,
    input  logic [ROW_W-1:0]              coef_bot,
    output logic [7:0]                    red_q,
    output logic [7:0]                    green_q,
    output logic [7:0]                    blue_q
);

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] above, above2;
    logic [PIX_W-1:0] win_reg [9];
    logic [3:0]       tap_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [SUM_W-1:0] csum_reg;
    logic [QW-1:0]    rem_reg [3];
    logic [QW-1:0]    quo_reg [3];
    logic [SUM_W-1:0] dvs_reg;
    logic [2:0]       neg_reg;
    logic [4:0]       bit_reg;
    logic             div_busy_reg;
    logic [ROW_W-1:0] row_bits;
    logic signed [COEF_W-1:0] k;
    logic [PIX_W-1:0] p;
    logic signed [SUM_W-1:0] csum_fix;

    rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk(clk), .we(cmd.shift), .addr(col_idx), .wdata(pix_reg), .rdata(above));
    rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk(clk), .we(cmd.shift), .addr(col_idx), .wdata(above), .rdata(above2));

    always_comb
    begin
        unique case (tap_reg) inside
            [4'd0:4'd2]: row_bits = coef_top;
            [4'd3:4'd5]: row_bits = coef_mid;
            default:     row_bits = coef_bot;
        endcase
        unique case (tap_reg) inside
            4'd0, 4'd3, 4'd6: k = $signed(row_bits[15:0]);
            4'd1, 4'd4, 4'd7: k = $signed(row_bits[31:16]);
            default:          k = $signed(row_bits[47:32]);
        endcase
        p = win_reg[tap_reg];
        csum_fix = (csum_reg == '0) ? SUM_W'(256) : csum_reg;
    end

    assign stat.tap_last = (tap_reg == 4'd8);
    assign stat.div_done = div_busy_reg && (bit_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
            tap_reg      <= '0;
            div_busy_reg <= 1'b0;
            bit_reg      <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[3*r]   <= win_reg[3*r+1];
                    win_reg[3*r+1] <= win_reg[3*r+2];
                end
                win_reg[2] <= above2;
                win_reg[5] <= above;
                win_reg[8] <= pix_reg;
            end
            if (cmd.mac_clr)
                tap_reg <= '0;
            else if (cmd.mac_step && tap_reg != 4'd8)
                tap_reg <= tap_reg + 4'd1;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                bit_reg      <= 5'(QW - 1);
            end
            else if (div_busy_reg)
            begin
                if (bit_reg == 5'd0)
                    div_busy_reg <= 1'b0;
                else
                    bit_reg <= bit_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= pix_in;
        if (cmd.mac_clr)
        begin
            for (int c = 0; c < 3; c++) acc_reg[c] <= '0;
            csum_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= acc_reg[c]
                              + ACC_W'(k) * ACC_W'($signed({1'b0, p[8*c +: 8]}));
            csum_reg <= csum_reg + SUM_W'(k);
        end
        if (cmd.div_start)
        begin
            dvs_reg <= csum_fix[SUM_W-1] ? SUM_W'(-csum_fix) : csum_fix;
            for (int c = 0; c < 3; c++)
            begin
                neg_reg[c] <= acc_reg[c][ACC_W-1] ^ csum_fix[SUM_W-1];
                quo_reg[c] <= acc_reg[c][ACC_W-1] ? QW'(-acc_reg[c]) : QW'(acc_reg[c]);
                rem_reg[c] <= '0;
            end
        end
        else if (div_busy_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [QW:0] trial;
                trial = {rem_reg[c], quo_reg[c][QW-1]} - {(QW+1-SUM_W)'(0), dvs_reg};
                if (!trial[QW])
                begin
                    rem_reg[c] <= trial[QW-1:0];
                    quo_reg[c] <= {quo_reg[c][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= {rem_reg[c][QW-2:0], quo_reg[c][QW-1]};
                    quo_reg[c] <= {quo_reg[c][QW-2:0], 1'b0};
                end
            end
        end
    end

    function automatic logic [7:0] sat(input logic [QW-1:0] q, input logic n);
        logic [7:0] r;
        if (n || q == '0)
            r = 8'd0;
        else if (q > QW'(255))
            r = 8'd255;
        else
            r = q[7:0];
        return r;
    endfunction

    assign red_q   = sat(quo_reg[0], neg_reg[0]);
    assign green_q = sat(quo_reg[1], neg_reg[1]);
    assign blue_q  = sat(quo_reg[2], neg_reg[2]);

    tap_bound: assert property (@(posedge clk) disable iff (!rst_n) tap_reg <= 4'd8)
        else $error("tap index out of range");
    div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg)
        else $error("divider did not start");
    div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy_reg |-> bit_reg == 5'd0 || $past(cmd.div_start) || !$past(rst_n))
        else $error("divider counter stray");

endmodule

// ===== hw/rtl/rkc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkc_ctrl
// sequencer of the filter: counters, handshake and datapath commands
// ----------------------------------------------------------------------------
module rkc_ctrl import rkc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         frame_start,
    input  logic                         out_stall,
    output logic                         out_valid,
    input  logic [10:0]                  image_width,
    input  logic [12:0]                  image_height,
    output rkc_cmd_t                     cmd,
    input  rkc_stat_t                    stat,
    output logic [$clog2(MAX_WIDTH)-1:0] col_idx,
    output logic [9:0]                   pos_x,
    output logic [11:0]                  pos_y,
    output logic                         frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_MAC, S_START, S_DIV, S_OUT} state_t;

    state_t      state_reg;
    logic [12:0] col_reg;
    logic [12:0] row_reg;
    logic        prod_reg;
    logic        out_valid_reg;
    logic [9:0]  px_reg;
    logic [11:0] py_reg;
    logic        last_reg;
    logic [12:0] w, h;
    logic [12:0] col_next, row_next;
    logic        accept;

    always_comb
    begin
        if (image_width < 11'd3)
            w = 13'd3;
        else if (13'(image_width) > 13'(MAX_WIDTH))
            w = 13'(MAX_WIDTH);
        else
            w = 13'(image_width);
        if (image_height < 13'd3)
            h = 13'd3;
        else if (image_height > 13'd4096)
            h = 13'd4096;
        else
            h = image_height;
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid  = out_valid_reg;
    assign pos_x      = px_reg;
    assign pos_y      = py_reg;
    assign frame_last = last_reg;
    assign col_idx    = AW'(col_reg);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.shift     = (state_reg == S_SHIFT);
        cmd.mac_clr   = (state_reg == S_SHIFT);
        cmd.mac_step  = (state_reg == S_MAC);
        cmd.div_start = (state_reg == S_START);
        cmd.out_load  = (state_reg == S_OUT);
        col_next = col_reg + 13'd1;
        row_next = row_reg;
        if (col_next >= w)
        begin
            col_next = '0;
            row_next = row_reg + 13'd1;
            if (row_next >= h)
                row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            prod_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (frame_start)
                        begin
                            col_reg <= '0;
                            row_reg <= '0;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    prod_reg <= col_reg >= 13'd2 && row_reg >= 13'd2
                                && col_reg < w && row_reg < h;
                    px_reg   <= 10'(col_reg - 13'd1);
                    py_reg   <= 12'(row_reg - 13'd1);
                    last_reg <= (col_reg == w - 13'd1) && (row_reg == h - 13'd1);
                    col_reg  <= col_next;
                    row_reg  <= row_next;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (stat.tap_last)
                        state_reg <= prod_reg ? S_START : S_IDLE;
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (stat.div_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("result dropped under stall");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("item not started");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> !(out_valid_reg && out_stall))
        else $error("result overwritten");

endmodule

// ===== hw/rtl/rgb_kernel_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_3x3
// normalized 3x3 convolution over a raster rgb pixel stream
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  pixel    in         in_valid/in_stall    red_in green_in blue_in frame_start
//  result   out        out_valid/out_stall  rgb out, pos_x pos_y frame_last
//  config   in         cfg_we               cfg_index cfg_data
//
//  an item runs through line store read, window shift and nine taps on one
//  multiplier per channel; an item with a result then adds divider start,
//  29 steps of the restoring divider and result capture. a new pixel is taken only when idle.
//  line stores are not cleared after reset.
//  a pending stalled result holds off the next item.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_3x3 import rkc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [9:0]  pos_x,
    output logic [11:0] pos_y,
    output logic        frame_last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [ROW_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [7:0]       r_q, g_q, b_q;
    logic [7:0]       r_reg, g_reg, b_reg;
    rkc_cmd_t         cmd;
    rkc_stat_t        stat;
    logic [$clog2(MAX_WIDTH)-1:0] col_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= '0;
            coef_mid_reg <= 48'h1000000;
            coef_bot_reg <= '0;
            width_reg    <= 11'd1024;
            height_reg   <= 13'd768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP:    coef_top_reg <= cfg_data;
                REG_MID:    coef_mid_reg <= cfg_data;
                REG_BOT:    coef_bot_reg <= cfg_data;
                REG_WIDTH:  width_reg    <= cfg_data[10:0];
                REG_HEIGHT: height_reg   <= cfg_data[12:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            r_reg <= r_q;
            g_reg <= g_q;
            b_reg <= b_q;
        end
    end

    assign red_out   = r_reg;
    assign green_out = g_reg;
    assign blue_out  = b_reg;

    rkc_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .frame_start(frame_start), .out_stall(out_stall), .out_valid(out_valid),
        .image_width(width_reg), .image_height(height_reg), .cmd(cmd), .stat(stat),
        .col_idx(col_idx), .pos_x(pos_x), .pos_y(pos_y), .frame_last(frame_last));

    rkc_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .col_idx(col_idx),
        .pix_in({blue_in, green_in, red_in}), .coef_top(coef_top_reg),
        .coef_mid(coef_mid_reg), .coef_bot(coef_bot_reg),
        .red_q(r_q), .green_q(g_q), .blue_q(b_q));

endmodule
